[sv/png_scanline_unfilter_defines.svh]
// ---------------------------------------------------------------------------
// PNG scanline unfilter assertion macros
// Shared property forms for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef PNG_SCANLINE_UNFILTER_DEFINES_SVH
`define PNG_SCANLINE_UNFILTER_DEFINES_SVH

// Same-cycle implication, sampled on clk and idle while rst_n is low.
`define PNGU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and idle while rst_n is low.
`define PNGU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/pngu_pkg.sv]
// ---------------------------------------------------------------------------
// PNG scanline unfilter package
// Sizes, register map, filter codes and the Paeth predictor.
// ---------------------------------------------------------------------------
package pngu_pkg;

  localparam int MAX_WIDTH    = 2048;
  localparam int MAX_CHANNELS = 4;
  localparam int ROW_LIMIT    = 2048;
  localparam int STORE_DEPTH  = MAX_WIDTH * MAX_CHANNELS;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int COL_W        = 13;
  localparam int ROW_W        = 11;
  localparam int LEN_W        = 15;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_BPP    = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // Row filter types.
  localparam logic [2:0] FLT_NONE  = 3'd0;
  localparam logic [2:0] FLT_SUB   = 3'd1;
  localparam logic [2:0] FLT_UP    = 3'd2;
  localparam logic [2:0] FLT_AVG   = 3'd3;
  localparam logic [2:0] FLT_PAETH = 3'd4;
  localparam logic [7:0] FLT_LAST  = 8'd4;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_DATA  = 2'd1,
    OP_ERROR = 2'd2
  } pngu_op_t;

  // One item in the reconstruction stage.
  typedef struct packed {
    pngu_op_t         op;
    logic [7:0]       data;
    logic [1:0]       ch;
    logic [COL_W-1:0] col;
    logic [2:0]       filter;
    logic             row0;
    logic             gray;
    logic             emit;
    logic             done;
  } pngu_item_t;

  function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    logic signed [9:0] da;
    logic signed [9:0] db;
    logic signed [9:0] dc;
    da = $signed({2'b00, b}) - $signed({2'b00, c});
    db = $signed({2'b00, a}) - $signed({2'b00, c});
    dc = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
    if (da < 0) da = -da;
    if (db < 0) db = -db;
    if (dc < 0) dc = -dc;
    if (da <= db && da <= dc) return a;
    if (db <= dc) return b;
    return c;
  endfunction

endpackage

[sv/png_scanline_unfilter.sv]
// ---------------------------------------------------------------------------
// PNG scanline unfilter
// Rebuilds filtered PNG rows from a byte stream and emits 24-bit RGB pixels.
// ---------------------------------------------------------------------------
// The block takes one inflated scanline byte per item and sustains one item
// per clock cycle unless results stall, with no bubbles between rows. Each
// row opens with its filter byte, which produces no result; every data byte
// that completes a pixel produces one result, which is registered first in the
// reconstruction stage and then the output register. The previous row lives in
// an 8192-byte synchronous memory with one read and one write port: the read
// for a byte is issued on the edge that accepts it, and the rebuilt byte is
// written back at the same column when it leaves the reconstruction stage.
// That memory is not cleared; row 0 takes zero in place of its read data.
// Gray and gray+alpha pixels are replicated to RGB, alpha is dropped,
// and the last pixel of the image carries out_tlast. A filter byte above 4
// yields one result with out_tuser set, after which input is taken and dropped
// until reset. Registers: bytes_per_pixel at 0x0, image_width at 0x4 and
// image_height at 0x8; change them only while the block is idle.
module png_scanline_unfilter import pngu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] stream_byte
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [23:0] pixel_rgb
  output logic        out_tuser,  // [0] bad_filter
  output logic        out_tlast,  // image_done
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // ---------------------------------------------------------------- config
  logic [2:0]  bpp_r;
  logic [11:0] width_r;
  logic [11:0] height_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r    <= 3'd3;
      width_r  <= 12'd1;
      height_r <= 12'd1;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_BPP:    bpp_r    <= cfg_pwdata[2:0];
        REG_WIDTH:  width_r  <= cfg_pwdata[11:0];
        REG_HEIGHT: height_r <= cfg_pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_BPP:    cfg_prdata = {29'd0, bpp_r};
      REG_WIDTH:  cfg_prdata = {20'd0, width_r};
      REG_HEIGHT: cfg_prdata = {20'd0, height_r};
      default:    cfg_prdata = 32'd0;
    endcase
  end

  // Out-of-range register values are clamped to the nearest legal one.
  logic [2:0]       eff_bpp;
  logic [11:0]      eff_width;
  logic [11:0]      eff_height;
  logic [LEN_W-1:0] row_len;

  always_comb begin
    if (bpp_r == 3'd0) begin
      eff_bpp = 3'd1;
    end else if (int'(bpp_r) > MAX_CHANNELS) begin
      eff_bpp = 3'(MAX_CHANNELS);
    end else begin
      eff_bpp = bpp_r;
    end
    if (width_r == 12'd0) begin
      eff_width = 12'd1;
    end else if (int'(width_r) > MAX_WIDTH) begin
      eff_width = 12'(MAX_WIDTH);
    end else begin
      eff_width = width_r;
    end
    if (height_r == 12'd0) begin
      eff_height = 12'd1;
    end else if (int'(height_r) > ROW_LIMIT) begin
      eff_height = 12'(ROW_LIMIT);
    end else begin
      eff_height = height_r;
    end
    row_len = LEN_W'(eff_width) * LEN_W'(eff_bpp);
  end

  // ---------------------------------------------------------------- handshake
  // The reconstruction stage moves on when its byte emits no result or the
  // output register is free or being emptied this cycle; the input side is
  // ready whenever that stage is empty or moving.
  logic       s1_valid_r;
  pngu_item_t s1_item_r;
  logic       out_valid_r;
  logic       out_free;
  logic       s1_adv;
  logic       in_acc;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && (!s1_item_r.emit || out_free);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  // ---------------------------------------------------------------- row control
  // All counters advance on acceptance; they never depend on rebuilt data, so
  // the byte's column, channel and end-of-row flags are known before the
  // memory read returns.
  logic             expect_r;
  logic             failed_r;
  logic [2:0]       filter_r;
  logic [COL_W-1:0] col_r;
  logic [1:0]       ch_r;
  logic [ROW_W-1:0] row_r;

  logic             expect_nxt;
  logic             failed_nxt;
  logic [2:0]       filter_nxt;
  logic [COL_W-1:0] col_nxt;
  logic [1:0]       ch_nxt;
  logic [ROW_W-1:0] row_nxt;
  logic             pass_item;
  pngu_item_t       item_nxt;

  logic [COL_W-1:0] col_inc;
  logic             emit;
  logic             row_end;
  logic             last_row;

  always_comb begin
    col_inc  = col_r + COL_W'(1);
    emit     = ({1'b0, ch_r} + 3'd1) >= eff_bpp;
    row_end  = (LEN_W'(col_inc) >= row_len) || (col_inc == '0);
    last_row = ({1'b0, row_r} + 12'd1) >= eff_height;

    expect_nxt = expect_r;
    failed_nxt = failed_r;
    filter_nxt = filter_r;
    col_nxt    = col_r;
    ch_nxt     = ch_r;
    row_nxt    = row_r;
    pass_item  = 1'b0;

    item_nxt        = '0;
    item_nxt.data   = in_tdata;
    item_nxt.ch     = ch_r;
    item_nxt.col    = col_r;
    item_nxt.filter = filter_r;
    item_nxt.row0   = (row_r == '0);
    item_nxt.gray   = (eff_bpp <= 3'd2);

    if (in_acc && !failed_r) begin
      pass_item = 1'b1;
      if (expect_r) begin
        if (in_tdata > FLT_LAST) begin
          failed_nxt    = 1'b1;
          item_nxt.op   = OP_ERROR;
          item_nxt.emit = 1'b1;
        end else begin
          filter_nxt  = in_tdata[2:0];
          expect_nxt  = 1'b0;
          col_nxt     = '0;
          ch_nxt      = '0;
          item_nxt.op = OP_CLEAR;
        end
      end else begin
        item_nxt.op   = OP_DATA;
        item_nxt.emit = emit;
        item_nxt.done = emit && row_end && last_row;
        col_nxt       = col_inc;
        ch_nxt        = emit ? 2'd0 : ch_r + 2'd1;
        if (row_end) begin
          expect_nxt = 1'b1;
          ch_nxt     = '0;
          col_nxt    = '0;
          row_nxt    = last_row ? '0 : row_r + ROW_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_r <= 1'b1;
      failed_r <= 1'b0;
      filter_r <= FLT_NONE;
      col_r    <= '0;
      ch_r     <= '0;
      row_r    <= '0;
    end else begin
      expect_r <= expect_nxt;
      failed_r <= failed_nxt;
      filter_r <= filter_nxt;
      col_r    <= col_nxt;
      ch_r     <= ch_nxt;
      row_r    <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= pass_item;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= item_nxt;
    end
  end

  // ---------------------------------------------------------------- prior row
  // Consecutive data bytes never share a column: a row end, and with it a
  // filter byte, lies between any two uses of the same column, so the write
  // from the stage always lands before the next read of it.
  logic [7:0]        prior_mem [STORE_DEPTH];
  logic [7:0]        rd_data_r;
  logic              mem_rd;
  logic              mem_wr;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        v;

  assign mem_rd  = pass_item && !expect_r;
  assign rd_addr = ADDR_W'(col_r);
  assign mem_wr  = s1_adv && (s1_item_r.op == OP_DATA);
  assign wr_addr = ADDR_W'(s1_item_r.col);

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      prior_mem[wr_addr] <= v;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_rd) begin
      rd_data_r <= prior_mem[rd_addr];
    end
  end

  // ---------------------------------------------------------------- rebuild
  // Left and upper-left neighbors are kept per channel; the upper neighbor of
  // this byte becomes the upper-left neighbor of the same channel one pixel on.
  logic [7:0]  left_r [MAX_CHANNELS];
  logic [7:0]  upleft_r [MAX_CHANNELS];
  logic [23:0] gather_r;

  logic [7:0]  nb_a;
  logic [7:0]  nb_b;
  logic [7:0]  nb_c;
  logic [7:0]  pred;
  logic [8:0]  avg_sum;
  logic [23:0] gather_nxt;

  always_comb begin
    nb_a    = left_r[s1_item_r.ch];
    nb_c    = upleft_r[s1_item_r.ch];
    nb_b    = s1_item_r.row0 ? 8'd0 : rd_data_r;
    avg_sum = {1'b0, nb_a} + {1'b0, nb_b};
    case (s1_item_r.filter)
      FLT_SUB:   pred = nb_a;
      FLT_UP:    pred = nb_b;
      FLT_AVG:   pred = avg_sum[8:1];
      FLT_PAETH: pred = paeth_pick(nb_a, nb_b, nb_c);
      default:   pred = 8'd0;
    endcase
    v = s1_item_r.data + pred;

    gather_nxt = gather_r;
    if (s1_item_r.gray) begin
      if (s1_item_r.ch == 2'd0) gather_nxt = {v, v, v};
    end else begin
      case (s1_item_r.ch)
        2'd0:    gather_nxt[23:16] = v;
        2'd1:    gather_nxt[15:8]  = v;
        2'd2:    gather_nxt[7:0]   = v;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        left_r[i]   <= 8'd0;
        upleft_r[i] <= 8'd0;
      end
      gather_r <= 24'd0;
    end else if (s1_adv) begin
      case (s1_item_r.op)
        OP_CLEAR: begin
          for (int i = 0; i < MAX_CHANNELS; i++) begin
            left_r[i]   <= 8'd0;
            upleft_r[i] <= 8'd0;
          end
          gather_r <= 24'd0;
        end
        OP_DATA: begin
          left_r[s1_item_r.ch]   <= v;
          upleft_r[s1_item_r.ch] <= nb_b;
          gather_r <= s1_item_r.emit ? 24'd0 : gather_nxt;
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- output
  logic [23:0] out_data_r;
  logic        out_user_r;
  logic        out_last_r;
  logic        out_load;

  assign out_load = s1_adv && s1_item_r.emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= (s1_item_r.op == OP_ERROR) ? 24'd0 : gather_nxt;
      out_user_r <= (s1_item_r.op == OP_ERROR);
      out_last_r <= s1_item_r.done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

[sv/pngu_checker.sv]
// ---------------------------------------------------------------------------
// PNG scanline unfilter checker
// Port-level checks on results and the configuration port.
// ---------------------------------------------------------------------------
`include "png_scanline_unfilter_defines.svh"

module pngu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast,
  input logic        cfg_psel,
  input logic        cfg_pready
);

  // A stalled result keeps its contents.
  `PNGU_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "result changed while stalled")

  // An error result has no pixel and never closes the image.
  `PNGU_ASSERT_NOW(a_err_shape, out_tvalid && out_tuser, out_tdata == 24'd0 && !out_tlast, "error result carries pixel data or end mark")

  // Nothing follows an error result until reset.
  `PNGU_ASSERT_NEXT(a_err_final, out_tvalid && out_tready && out_tuser, !out_tvalid, "result after an error")

  // The configuration port never inserts wait states.
  `PNGU_ASSERT_NOW(a_cfg_ready, cfg_psel, cfg_pready, "configuration access stalled")

endmodule

bind png_scanline_unfilter pngu_checker u_pngu_checker (.*);

[verif/tb_png_scanline_unfilter.sv]
// ---------------------------------------------------------------------------
// PNG scanline unfilter testbench
// Streams filtered PNG rows into the block and checks every pixel against a
// cycle-free predictor of the row reconstruction and RGB packing.
// ---------------------------------------------------------------------------
module tb_png_scanline_unfilter;
  import pngu_pkg::*;

  // The watchdog limit is many times the slowest expected run: roughly
  // 2000 items, each of which can wait out a sender gap and a receiver stall.
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  // A byte passes the reconstruction stage and the output register; the settle
  // covers a filter byte or partial pixel still in flight after the last pixel.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_ITEMS  = 1700;
  localparam int unsigned HOLD_OFF      = 300;

  // One pixel result as the block should present it.
  typedef struct packed {
    logic [23:0] pixel_rgb;
    logic        bad_filter;
    logic        image_done;
  } pixel_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [7:0] stream_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // [23:0] pixel_rgb
  logic        out_tuser;  // [0] bad_filter
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  png_scanline_unfilter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Traffic shaping. The sender skips a cycle with probability send_idle_pct,
  // the receiver drops out_tready with probability stall_pct. A nonzero
  // hold_cycles makes the receiver refuse results until it counts down to zero.
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned hold_cycles;
  int unsigned items_sent;
  int unsigned fail_count;

  // Pixels that the predictor has produced and the block has not yet shown.
  pixel_result_t expected_pixels[$];

  // Predictor copy of the register file.
  logic [2:0]  cfg_bpp;
  logic [11:0] cfg_width;
  logic [11:0] cfg_height;

  // Predictor copy of the reconstruction state.
  logic [7:0]  prev_row[STORE_DEPTH];
  logic [7:0]  left_px[MAX_CHANNELS];
  logic [7:0]  upleft_px[MAX_CHANNELS];
  logic [12:0] col_pos;
  logic [10:0] row_idx;
  logic        want_filter;
  logic [2:0]  row_flt;
  logic [1:0]  chan;
  logic [23:0] gather;
  logic        dead;

  // Paeth chooses whichever neighbor lies closest to left + up - upper-left,
  // with ties going to left, then up.
  function automatic int paeth_choose(input int a, input int b, input int c);
    int dist_a;
    int dist_b;
    int dist_c;
    dist_a = (b > c) ? b - c : c - b;
    dist_b = (a > c) ? a - c : c - a;
    dist_c = (a + b > 2 * c) ? a + b - 2 * c : 2 * c - a - b;
    if (dist_a <= dist_b && dist_a <= dist_c) return a;
    if (dist_b <= dist_c) return b;
    return c;
  endfunction

  // Advances the predictor by one accepted stream byte and queues the pixel
  // it completes, if any.
  task automatic unfilter_byte(input logic [7:0] data);
    int            bpp;
    int            width;
    int            height;
    int            ch;
    int            a;
    int            b;
    int            c;
    int            pred;
    logic [7:0]    v;
    logic          emit;
    logic          last_row;
    pixel_result_t res;
    if (dead) return;
    if (want_filter) begin
      // A filter code past Paeth yields one error result and then the block
      // swallows everything until reset.
      if (data > FLT_LAST) begin
        dead = 1'b1;
        res = '{pixel_rgb: '0, bad_filter: 1'b1, image_done: 1'b0};
        expected_pixels.push_back(res);
        return;
      end
      row_flt = data[2:0];
      want_filter = 1'b0;
      col_pos = '0;
      chan = '0;
      gather = '0;
      foreach (left_px[i]) begin
        left_px[i] = '0;
        upleft_px[i] = '0;
      end
      return;
    end

    // Out-of-range register values are clamped, not rejected.
    bpp    = (cfg_bpp == 0) ? 1 : ((cfg_bpp > MAX_CHANNELS) ? MAX_CHANNELS : cfg_bpp);
    width  = (cfg_width == 0) ? 1 : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width);
    height = (cfg_height == 0) ? 1 : ((cfg_height > ROW_LIMIT) ? ROW_LIMIT : cfg_height);

    ch = chan;
    a  = left_px[ch];
    b  = (row_idx != 0) ? int'(prev_row[col_pos]) : 0;
    c  = upleft_px[ch];
    case (row_flt)
      FLT_SUB:   pred = a;
      FLT_UP:    pred = b;
      FLT_AVG:   pred = (a + b) >> 1;
      FLT_PAETH: pred = paeth_choose(a, b, c);
      default:   pred = 0;
    endcase
    v = 8'(int'(data) + pred);

    left_px[ch]      = v;
    upleft_px[ch]    = 8'(b);
    prev_row[col_pos] = v;

    // Gray (with or without alpha) fills all three colors from the first
    // byte; color pixels place bytes 0..2 as red, green, blue and drop alpha.
    if (bpp <= 2) begin
      if (ch == 0) gather = {v, v, v};
    end else if (ch < 3) begin
      gather[8 * (2 - ch) +: 8] = v;
    end

    emit = (ch + 1 >= bpp);
    chan = emit ? 2'd0 : 2'(ch + 1);
    col_pos = col_pos + 13'd1;
    res = '{pixel_rgb: gather, bad_filter: 1'b0, image_done: 1'b0};

    // A row closes at its length or when the column counter wraps; the
    // closing byte of the last row also marks the image end if it ends a pixel.
    if (col_pos >= width * bpp || col_pos == 0) begin
      last_row = (int'(row_idx) + 1 >= height);
      if (emit && last_row) res.image_done = 1'b1;
      want_filter = 1'b1;
      chan = '0;
      col_pos = '0;
      row_idx = last_row ? 11'd0 : row_idx + 11'd1;
    end

    if (emit) begin
      expected_pixels.push_back(res);
      gather = '0;
    end
  endtask

  // Offers one byte, waits for it to be taken and runs the predictor on it.
  // Starts and ends on a falling edge.
  task automatic send_byte(input logic [7:0] data);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    unfilter_byte(data);
    @(negedge clk);
  endtask

  // Two-phase register write; the register takes the value on the access edge.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      REG_BPP:    cfg_bpp = value[2:0];
      REG_WIDTH:  cfg_width = value[11:0];
      REG_HEIGHT: cfg_height = value[11:0];
      default:    ;
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic configure(input logic [31:0] bpp, input logic [31:0] width,
                           input logic [31:0] height);
    write_reg(REG_BPP, bpp);
    write_reg(REG_WIDTH, width);
    write_reg(REG_HEIGHT, height);
  endtask

  // Stops offering input and waits until every pending pixel has arrived and
  // any byte that completes no pixel has left the pipeline.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_filter();
    return 8'($urandom_range(0, int'(FLT_LAST)));
  endfunction

  task automatic send_row(input logic [7:0] filter);
    send_byte(filter);
    while (!want_filter) send_byte(8'($urandom_range(0, 255)));
  endtask

  // Completes whatever row and image is open so that the next byte is the
  // filter byte of row 0.
  task automatic finish_image();
    while (!(want_filter && row_idx == 0)) begin
      if (want_filter) send_byte(pick_filter());
      else send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic set_traffic(input int unsigned idle, input int unsigned stall);
    send_idle_pct = idle;
    stall_pct = stall;
  endtask

  // Registers as they come out of reset: RGB, one pixel, one row.
  task automatic test_reset_values();
    set_traffic(0, 0);
    send_byte(FLT_NONE);
    send_byte(8'h12);
    send_byte(8'h34);
    send_byte(8'h56);
    drain_results();
  endtask

  // One gray row per filter type, with bytes at both extremes so that the
  // predictors see zero, full-scale and wrapping sums.
  task automatic test_filter_rows();
    set_traffic(0, 0);
    configure(1, 2, 5);
    send_byte(FLT_NONE);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(FLT_SUB);
    send_byte(8'h80);
    send_byte(8'hFF);
    send_byte(FLT_UP);
    send_byte(8'h01);
    send_byte(8'hFF);
    send_byte(FLT_AVG);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(FLT_PAETH);
    send_byte(8'h00);
    send_byte(8'h7F);
    drain_results();
  endtask

  // Gray with alpha replicates the gray byte and drops the alpha byte.
  task automatic test_gray_alpha();
    set_traffic(0, 0);
    configure(2, 1, 1);
    send_byte(FLT_SUB);
    send_byte(8'hAB);
    send_byte(8'hCD);
    drain_results();
  endtask

  // Out-of-range registers: a channel count above four acts as four, and
  // zero in any register acts as one.
  task automatic test_config_extremes();
    set_traffic(25, 25);
    configure(7, 3, 1);
    send_row(pick_filter());
    drain_results();
    configure(0, 0, 0);
    send_row(pick_filter());
    drain_results();
  endtask

  // Registers rewritten inside an image. Only shrinking the row is safe,
  // since a longer row would read prior-row bytes that were never written.
  task automatic test_mid_image_change();
    set_traffic(61, 0);
    configure(1, 16, 4095);
    send_row(pick_filter());
    drain_results();
    write_reg(REG_WIDTH, 3);
    write_reg(REG_HEIGHT, 2);
    send_row(FLT_PAETH);
    drain_results();

    // Shrink the pixel while one is half gathered: the next byte ends both
    // the pixel and the row.
    configure(4, 2, 3);
    send_row(FLT_NONE);
    send_byte(FLT_AVG);
    repeat (6) send_byte(8'($urandom_range(0, 255)));
    drain_results();
    write_reg(REG_BPP, 2);
    finish_image();
    drain_results();
  endtask

  // Whole images with random content, under each traffic pattern. Now and
  // then an image is cut short by a smaller width and height.
  task automatic test_random_images();
    int unsigned phase;
    int unsigned start;
    logic        shrink;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_traffic(0, 0);
        1: set_traffic(61, 0);
        2: set_traffic(0, 61);
        default: set_traffic(25, 25);
      endcase
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS / 4) begin
        configure($urandom_range(0, 7),
                  ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12),
                  $urandom_range(0, 4));
        repeat ($urandom_range(1, 3)) begin
          shrink = ($urandom_range(7) == 0);
          send_row(pick_filter());
          if (shrink && row_idx != 0) begin
            drain_results();
            write_reg(REG_WIDTH, $urandom_range(0, cfg_width));
            write_reg(REG_HEIGHT, $urandom_range(0, 4));
          end
          finish_image();
        end
        drain_results();
      end
    end
  endtask

  // The receiver refuses results for a long stretch while the sender keeps
  // offering one gray pixel per item, so the block must stall its input.
  task automatic test_backpressure();
    set_traffic(0, 0);
    configure(1, 16, 4);
    hold_cycles = HOLD_OFF;
    finish_image();
    send_row(pick_filter());
    finish_image();
    drain_results();
  endtask

  // A filter code past Paeth: one error result, then every byte is dropped.
  // This runs last because only a reset revives the block.
  task automatic test_bad_filter();
    set_traffic(25, 25);
    send_byte(8'($urandom_range(int'(FLT_LAST) + 1, 255)));
    repeat (12) send_byte(8'($urandom_range(0, 255)));
    drain_results();
    write_reg(REG_BPP, 1);
    repeat (4) send_byte(FLT_NONE);
    drain_results();
  endtask

  // The receiver decides out_tready one cycle at a time.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_tready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end
  end

  // Every accepted result must match the oldest pending pixel field by field.
  always @(posedge clk) begin : check_results
    pixel_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected result: pixel_rgb %06h bad_filter %0b image_done %0b",
               out_tdata, out_tuser, out_tlast);
        fail_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (out_tdata !== want.pixel_rgb) begin
          $error("pixel_rgb: expected %06h, got %06h", want.pixel_rgb, out_tdata);
          fail_count++;
        end
        if (out_tuser !== want.bad_filter) begin
          $error("bad_filter: expected %0b, got %0b", want.bad_filter, out_tuser);
          fail_count++;
        end
        if (out_tlast !== want.image_done) begin
          $error("image_done: expected %0b, got %0b", want.image_done, out_tlast);
          fail_count++;
        end
      end
    end
  end

  // A hung handshake ends the run here.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_cycles   = 0;
    items_sent    = 0;
    fail_count    = 0;

    // The predictor starts from the block's reset state.
    cfg_bpp     = 3'd3;
    cfg_width   = 12'd1;
    cfg_height  = 12'd1;
    col_pos     = '0;
    row_idx     = '0;
    want_filter = 1'b1;
    row_flt     = FLT_NONE;
    chan        = '0;
    gather      = '0;
    dead        = 1'b0;
    foreach (left_px[i]) begin
      left_px[i]   = '0;
      upleft_px[i] = '0;
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_values();
    test_filter_rows();
    test_gray_alpha();
    test_config_extremes();
    test_mid_image_change();
    test_random_images();
    test_backpressure();
    test_bad_filter();

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
